FILE: rtl/arngt_pkg.sv
// shared types, constants and codes for the auto-release note gate table
// no dependencies; imported by every module of the block
`default_nettype none

package arngt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int REG_W   = 23;
  localparam int REM_W   = 24;
  localparam int NOTE_W  = 7;
  localparam int MODE_W  = 2;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 2;

  localparam logic [REG_W-1:0] GATE_RESET = REG_W'(750000);
  localparam logic [REG_W-1:0] HOLD_RESET = REG_W'(160000);
  localparam logic [REG_W-1:0] STEP_RESET = REG_W'(21333);

  localparam logic [MODE_W-1:0] MODE_KEY   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ON      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OFF     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ALL_OFF = 2'd2;

  localparam logic [CFG_W-1:0] CFG_GATE = 2'd0;
  localparam logic [CFG_W-1:0] CFG_HOLD = 2'd1;
  localparam logic [CFG_W-1:0] CFG_STEP = 2'd2;

  // one entry as seen at the table read port
  typedef struct packed {
    logic              active;
    logic [NOTE_W-1:0] note;
    logic [REM_W-1:0]  rem;
  } arngt_rd_t;

  // one write into the table
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic              active;
    logic              note_en;
    logic [NOTE_W-1:0] note;
    logic [REM_W-1:0]  rem;
  } arngt_wr_t;

  // results of the shared compare / subtract unit
  typedef struct packed {
    logic             le;
    logic             eq;
    logic [REM_W-1:0] diff;
  } arngt_alu_t;

endpackage

`default_nettype wire

FILE: rtl/auto_release_note_gate_table.sv
// top level of the auto-release note gate table: sequencer and registers
// depends on arngt_pkg, arngt_alu and arngt_table
`default_nettype none

// usage
//  - an item (mode_i, note_i) is taken at a clock edge with start_i high
//    and busy_o low; busy_o stays high while the table is swept
//  - key press and tick sweep all ENTRIES slots, one per cycle, through one
//    shared compare / subtract unit; a key press ends early on a hit
//  - key press: busy for the sweep; note-on beat the cycle after, none on a hit
//  - tick: busy for the sweep plus a flush state; each note-off
//    beat is held back until the next one or the flush so that the final one can carry last_o
//  - clear: one all-notes-off beat the cycle after start, never busy
//  - mode three is dropped with no beat
//  - every result beat is on the ports for one cycle, marked by
//    result_valid_o; the receiver cannot stall, so no backpressure exists
//  - cfg_we_i writes gate, hold or tick step at once; other indexes ignored
//  - reset empties the table and loads the default register values

module auto_release_note_gate_table import arngt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [NOTE_W-1:0] note_i,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_idx_i,
  input  logic [REG_W-1:0]  cfg_data_i,
  output logic              result_valid_o,
  output logic [KIND_W-1:0] event_kind_o,
  output logic [NOTE_W-1:0] event_note_o,
  output logic              last_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  // configuration registers
  logic [REG_W-1:0] gate_q, hold_q, step_q;

  // sequencer state
  logic [1:0]        state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              tick_q, tick_d;        // current item is a tick
  logic [NOTE_W-1:0] key_q, key_d;          // note of the key press
  logic              found_q, found_d;      // a free slot has been seen
  logic [IDX_W-1:0]  free_q, free_d;        // lowest free slot
  logic              pend_q, pend_d;        // a note-off waits for its beat
  logic [NOTE_W-1:0] pend_note_q, pend_note_d;

  // result beat register
  logic              vld_q, vld_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [NOTE_W-1:0] enote_q, enote_d;
  logic              last_q, last_d;

  arngt_rd_t  rd;
  arngt_wr_t  wr;
  arngt_alu_t alu;
  logic       clear;
  logic       accept;

  arngt_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (clear),
    .rd_idx_i (idx_q),
    .rd_o     (rd),
    .wr_i     (wr)
  );

  arngt_alu u_alu (
    .rem_i    (rd.rem),
    .step_i   (step_q),
    .note_a_i (rd.note),
    .note_b_i (key_q),
    .res_o    (alu)
  );

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q <= GATE_RESET;
      hold_q <= HOLD_RESET;
      step_q <= STEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GATE: gate_q <= cfg_data_i;
        CFG_HOLD: hold_q <= cfg_data_i;
        CFG_STEP: step_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    tick_d      = tick_q;
    key_d       = key_q;
    found_d     = found_q;
    free_d      = free_q;
    pend_d      = pend_q;
    pend_note_d = pend_note_q;
    vld_d       = 1'b0;
    kind_d      = kind_q;
    enote_d     = enote_q;
    last_d      = last_q;
    clear       = 1'b0;
    wr          = '0;
    wr.idx      = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          found_d = 1'b0;
          pend_d  = 1'b0;
          key_d   = note_i;
          tick_d  = (mode_i == MODE_TICK);
          if (mode_i == MODE_KEY || mode_i == MODE_TICK) begin
            state_d = ST_SWEEP;
          end else if (mode_i == MODE_CLEAR) begin
            clear   = 1'b1;
            vld_d   = 1'b1;
            kind_d  = KIND_ALL_OFF;
            enote_d = '0;
            last_d  = 1'b1;
          end
        end
      end

      ST_SWEEP: begin
        idx_d = idx_q + 1'b1;
        if (tick_q) begin
          // tick: expire or count down each active slot
          if (rd.active) begin
            wr.en = 1'b1;
            if (alu.le) begin
              wr.active   = 1'b0;
              wr.rem      = '0;
              pend_d      = 1'b1;
              pend_note_d = rd.note;
              if (pend_q) begin
                vld_d   = 1'b1;
                kind_d  = KIND_OFF;
                enote_d = pend_note_q;
                last_d  = 1'b0;
              end
            end else begin
              wr.active = 1'b1;
              wr.rem    = alu.diff;
            end
          end
          if (idx_q == IDX_LAST) begin
            state_d = ST_FLUSH;
          end
        end else if (rd.active && alu.eq) begin
          // repeated press of a sounding note: refresh only
          wr.en     = 1'b1;
          wr.active = 1'b1;
          wr.rem    = {1'b0, hold_q};
          state_d   = ST_IDLE;
        end else begin
          if (!rd.active && !found_q) begin
            found_d = 1'b1;
            free_d  = idx_q;
          end
          if (idx_q == IDX_LAST) begin
            vld_d   = 1'b1;
            kind_d  = KIND_ON;
            enote_d = key_q;
            last_d  = 1'b1;
            state_d = ST_IDLE;
            // take the lowest free slot, if any
            if (found_q || !rd.active) begin
              wr.en      = 1'b1;
              wr.idx     = found_q ? free_q : idx_q;
              wr.active  = 1'b1;
              wr.note_en = 1'b1;
              wr.note    = key_q;
              wr.rem     = {1'b0, gate_q};
            end
          end
        end
      end

      ST_FLUSH: begin
        if (pend_q) begin
          vld_d   = 1'b1;
          kind_d  = KIND_OFF;
          enote_d = pend_note_q;
          last_d  = 1'b1;
        end
        pend_d  = 1'b0;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      tick_q  <= 1'b0;
      found_q <= 1'b0;
      pend_q  <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      tick_q  <= tick_d;
      found_q <= found_d;
      pend_q  <= pend_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    free_q      <= free_d;
    pend_note_q <= pend_note_d;
    kind_q      <= kind_d;
    enote_q     <= enote_d;
    last_q      <= last_d;
  end

  assign result_valid_o = vld_q;
  assign event_kind_o   = kind_q;
  assign event_note_o   = enote_q;
  assign last_o         = last_q;

  // a clear gives its all-notes-off beat on the next cycle
  a_clear_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i == MODE_CLEAR) |=> (result_valid_o && event_kind_o == KIND_ALL_OFF))
    else $error("clear did not give an all-notes-off beat");

  // note-on and all-notes-off are always the only beat of their item
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (event_kind_o == KIND_ON || event_kind_o == KIND_ALL_OFF)) |-> last_o)
    else $error("single-beat result without last");

  // a beat that is not last is followed by more work on the same item
  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy_o)
    else $error("non-final beat while idle");

  // a held note-off is only pending during a tick pass
  a_pend_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (busy_o && tick_q))
    else $error("pending note-off outside a tick pass");

endmodule

`default_nettype wire

FILE: rtl/arngt_alu.sv
// shared compare / subtract unit used once per swept entry
// depends on arngt_pkg
`default_nettype none

module arngt_alu import arngt_pkg::*; (
  input  logic [REM_W-1:0]  rem_i,
  input  logic [REG_W-1:0]  step_i,
  input  logic [NOTE_W-1:0] note_a_i,
  input  logic [NOTE_W-1:0] note_b_i,
  output arngt_alu_t        res_o
);

  logic [REM_W-1:0] step_ext;

  assign step_ext    = {1'b0, step_i};
  assign res_o.le    = (rem_i <= step_ext);
  assign res_o.diff  = rem_i - step_ext;
  assign res_o.eq    = (note_a_i == note_b_i);

endmodule

`default_nettype wire

FILE: rtl/arngt_table.sv
// entry table: active flags, note numbers and remaining times
// depends on arngt_pkg; one read index, one write, bulk clear of flags
`default_nettype none

module arngt_table import arngt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output arngt_rd_t        rd_o,
  input  arngt_wr_t        wr_i
);

  logic [ENTRIES-1:0] active_q;
  logic [NOTE_W-1:0]  note_q [ENTRIES];
  logic [REM_W-1:0]   rem_q  [ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (clear_i) begin
      active_q <= '0;
    end else if (wr_i.en) begin
      active_q[wr_i.idx] <= wr_i.active;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      rem_q[wr_i.idx] <= wr_i.rem;
      if (wr_i.note_en) begin
        note_q[wr_i.idx] <= wr_i.note;
      end
    end
  end

  assign rd_o.active = active_q[rd_idx_i];
  assign rd_o.note   = note_q[rd_idx_i];
  assign rd_o.rem    = rem_q[rd_idx_i];

endmodule

`default_nettype wire
